>>> rtl/rsi_pkg.sv
// rsi_pkg: widths, result limits and sideband structs for the ray-sphere test.
// No dependencies. Used by every module in rtl/.
`default_nettype none

package rsi_pkg;

  // fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int COORD_W  = 32;
  localparam int RADIUS_W = 31;
  localparam int T_W      = 32;

  // internal widths, all exact
  localparam int OC_W    = COORD_W + 1;  // origin - center
  localparam int A_W     = 64;           // |dir|^2
  localparam int HB_W    = 67;           // oc . dir
  localparam int C_W     = 68;           // |oc|^2 - r^2
  localparam int HBM_W   = 66;           // |half_b|
  localparam int CM_W    = 66;           // |c|
  localparam int DISC_W  = 132;          // discriminant
  localparam int ROOT_W  = DISC_W / 2;   // integer square root
  localparam int NUM_W   = 68;           // -half_b -/+ root, signed
  localparam int Q_W     = 33;           // quotient bits before saturation
  localparam int LIMB_W  = 32;           // multiplier limb
  localparam int MUL_LAT = 3;            // limb multiplier stages

  localparam logic [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
  localparam logic [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

  // carried alongside the square-root row
  typedef struct packed {
    logic [A_W-1:0]         a;
    logic signed [HB_W-1:0] hb;
    logic                   hit;
  } rsi_sq_side_t;

  // carried alongside the divider row, one bit per lane (near, far)
  typedef struct packed {
    logic       hit;
    logic [1:0] neg;
    logic [1:0] ovf;
  } rsi_div_side_t;

endpackage

`default_nettype wire

>>> rtl/rsi_mul.sv
// rsi_mul: unsigned multiplier built from 32x32 limb products, three stages.
// Depends on rsi_pkg (limb width).
`default_nettype none

module rsi_mul #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a_i,
  input  wire logic [BW-1:0] b_i,
  output logic [AW+BW-1:0]   p_o
);
  import rsi_pkg::*;

  localparam int LA    = (AW + LIMB_W - 1) / LIMB_W;
  localparam int LB    = (BW + LIMB_W - 1) / LIMB_W;
  localparam int ROW_W = (LB + 1) * LIMB_W;
  localparam int P_W   = (LA + LB) * LIMB_W;

  logic [LA*LIMB_W-1:0] a_ext;
  logic [LB*LIMB_W-1:0] b_ext;
  logic [2*LIMB_W-1:0]  pp_r [LA][LB];
  logic [ROW_W-1:0]     row_r [LA];
  logic [ROW_W-1:0]     row_nxt [LA];
  logic [P_W-1:0]       p_r;
  logic [P_W-1:0]       p_nxt;

  assign a_ext = (LA*LIMB_W)'(a_i);
  assign b_ext = (LB*LIMB_W)'(b_i);

  // limb products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp_r[i][j] <= a_ext[i*LIMB_W +: LIMB_W] * b_ext[j*LIMB_W +: LIMB_W];
        end
      end
    end
  end

  // one row per limb of a
  always_comb begin
    for (int i = 0; i < LA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LB; j++) begin
        row_nxt[i] = row_nxt[i] + (ROW_W'(pp_r[i][j]) << (j*LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
    end
  end

  // rows into the full product
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < LA; i++) begin
      p_nxt = p_nxt + (P_W'(row_r[i]) << (i*LIMB_W));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p_o = p_r[AW+BW-1:0];

endmodule

`default_nettype wire

>>> rtl/rsi_sqrt_cell.sv
// rsi_sqrt_cell: one cell of the square-root row, settles one root bit.
// Depends on rsi_pkg (widths, sideband struct).
`default_nettype none

module rsi_sqrt_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          vld_i,
  input  wire logic [rsi_pkg::ROOT_W:0]      rem_i,
  input  wire logic [rsi_pkg::ROOT_W-1:0]    root_i,
  input  wire logic [rsi_pkg::DISC_W-1:0]    rad_i,
  input  wire rsi_pkg::rsi_sq_side_t         side_i,
  output logic                               vld_o,
  output logic [rsi_pkg::ROOT_W:0]           rem_o,
  output logic [rsi_pkg::ROOT_W-1:0]         root_o,
  output logic [rsi_pkg::DISC_W-1:0]         rad_o,
  output rsi_pkg::rsi_sq_side_t              side_o
);
  import rsi_pkg::*;

  localparam int CUR_W = ROOT_W + 3;

  logic [CUR_W-1:0]  cur;
  logic [CUR_W-1:0]  trial;
  logic [CUR_W-1:0]  diff;
  logic              ge;
  logic              vld_r;
  logic [ROOT_W:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [DISC_W-1:0] rad_r, rad_nxt;
  rsi_sq_side_t      side_r;

  // bring down two radicand bits, try root*4+1
  assign cur   = {rem_i, rad_i[DISC_W-1 -: 2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_comb begin
    rem_nxt  = ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[DISC_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

>>> rtl/rsi_div_cell.sv
// rsi_div_cell: one cell of the divider row, one quotient bit for each of
// the near and far lanes, both over the same divisor. Depends on rsi_pkg.
`default_nettype none

module rsi_div_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            vld_i,
  input  wire logic [rsi_pkg::A_W-1:0]         dvs_i,
  input  wire logic [1:0][rsi_pkg::A_W-1:0]    rem_i,
  input  wire logic [1:0][rsi_pkg::Q_W-1:0]    low_i,
  input  wire logic [1:0][rsi_pkg::Q_W-1:0]    quo_i,
  input  wire rsi_pkg::rsi_div_side_t          side_i,
  output logic                                 vld_o,
  output logic [rsi_pkg::A_W-1:0]              dvs_o,
  output logic [1:0][rsi_pkg::A_W-1:0]         rem_o,
  output logic [1:0][rsi_pkg::Q_W-1:0]         low_o,
  output logic [1:0][rsi_pkg::Q_W-1:0]         quo_o,
  output rsi_pkg::rsi_div_side_t               side_o
);
  import rsi_pkg::*;

  logic [1:0][A_W:0]   cur;
  logic [1:0][A_W:0]   diff;
  logic [1:0]          ge;
  logic                vld_r;
  logic [A_W-1:0]      dvs_r;
  logic [1:0][A_W-1:0] rem_r, rem_nxt;
  logic [1:0][Q_W-1:0] low_r, low_nxt;
  logic [1:0][Q_W-1:0] quo_r, quo_nxt;
  rsi_div_side_t       side_r;

  // restoring step per lane
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      cur[k]     = {rem_i[k], low_i[k][Q_W-1]};
      ge[k]      = (cur[k] >= {1'b0, dvs_i});
      diff[k]    = cur[k] - {1'b0, dvs_i};
      rem_nxt[k] = ge[k] ? diff[k][A_W-1:0] : cur[k][A_W-1:0];
      quo_nxt[k] = {quo_i[k][Q_W-2:0], ge[k]};
      low_nxt[k] = {low_i[k][Q_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvs_r  <= dvs_i;
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign dvs_o  = dvs_r;
  assign rem_o  = rem_r;
  assign low_o  = low_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule

`default_nettype wire

>>> rtl/ray_sphere_intersection.sv
// ray_sphere_intersection: top level of the fixed-point ray-sphere test.
// Depends on rsi_pkg, rsi_mul, rsi_sqrt_cell and rsi_div_cell.
//
// Usage:
//  - input channel in_*: one beat carries a ray (origin, direction) and a
//    sphere (center, radius), signed fixed point with FRAC_BITS fraction
//    bits; taken at an edge where in_valid is high and in_stall is low
//  - result channel out_*: one beat per input beat, in order: out_hit and
//    the near and far ray parameters, both at the largest positive value
//    on a miss or on a zero direction
//  - throughput: one beat per cycle while in_stall is low, fully pipelined
//  - pipeline: the square-root row (one root bit per cell, 66 cells) and the
//    divider row (one quotient bit per cell, 33 cells) make up most of it;
//    the result is registered at the output
//  - receiver stall: the output register holds its beat; the pipeline keeps
//    moving and taking input until a finished beat reaches its last cell,
//    then the whole pipeline holds and in_stall rises
//  - reset (rst_n low, synchronous) empties every stage; no clearing pass
`default_nettype none

module ray_sphere_intersection #(
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_origin_x,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_origin_y,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_origin_z,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_dir_x,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_dir_y,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_dir_z,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_center_x,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_center_y,
  input  wire logic signed [rsi_pkg::COORD_W-1:0]   in_center_z,
  input  wire logic [rsi_pkg::RADIUS_W-1:0]         in_radius,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_hit,
  output logic signed [rsi_pkg::T_W-1:0]            out_t_near,
  output logic signed [rsi_pkg::T_W-1:0]            out_t_far
);
  import rsi_pkg::*;

  localparam int MAG_W = NUM_W - 1 + FRAC_BITS;
  localparam int HI_W  = MAG_W - Q_W;
  localparam logic [Q_W:0] NEG_LIM = {{(Q_W-T_W+1){1'b0}}, 1'b1, {(T_W-1){1'b0}}};

  logic adv;

  // input register
  logic                      vld0_r;
  logic signed [COORD_W-1:0] org_r [3];
  logic signed [COORD_W-1:0] dir_r [3];
  logic signed [COORD_W-1:0] ctr_r [3];
  logic [RADIUS_W-1:0]       rad_r;

  // oc stage
  logic                      vld1_r;
  logic signed [OC_W-1:0]    oc_r [3];
  logic signed [COORD_W-1:0] dir1_r [3];
  logic [RADIUS_W-1:0]       rad1_r;

  // product stage
  logic                              vld2_r;
  logic signed [2*COORD_W-1:0]       dd_r [3];
  logic signed [OC_W+COORD_W-1:0]    od_r [3];
  logic signed [2*OC_W-1:0]          oo_r [3];
  logic [2*RADIUS_W-1:0]             rr_r;

  // dot product stage
  logic                   vld3_r;
  logic [A_W-1:0]         a_r;
  logic signed [HB_W-1:0] hb_r, hb_nxt;
  logic signed [C_W-1:0]  c_r, c_nxt;

  // magnitude stage
  logic                   vld4_r;
  logic [A_W-1:0]         a4_r;
  logic signed [HB_W-1:0] hb4_r;
  logic                   cneg4_r;
  logic [HBM_W-1:0]       hbm_r;
  logic [CM_W-1:0]        cm_r;
  logic signed [HB_W-1:0] hb_abs;
  logic signed [C_W-1:0]  c_abs;

  // delay line next to the multipliers
  logic                   dly_vld_r [MUL_LAT];
  logic [A_W-1:0]         dly_a_r [MUL_LAT];
  logic signed [HB_W-1:0] dly_hb_r [MUL_LAT];
  logic                   dly_cneg_r [MUL_LAT];
  logic [2*HBM_W-1:0]     hb2;
  logic [A_W+CM_W-1:0]    ac;

  // discriminant stage
  logic              vld8_r;
  logic [DISC_W-1:0] disc8_r;
  rsi_sq_side_t      sq8_r;
  logic [DISC_W:0]   disc_w;
  logic              hit8;

  // square-root row
  logic              sq_vld  [0:ROOT_W];
  logic [ROOT_W:0]   sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0] sq_root [0:ROOT_W];
  logic [DISC_W-1:0] sq_rad  [0:ROOT_W];
  rsi_sq_side_t      sq_side [0:ROOT_W];

  // numerator stages
  logic                    vldn1_r, vldn2_r, vldn3_r;
  logic signed [NUM_W-1:0] num_r [2];
  logic signed [NUM_W-1:0] num_nxt [2];
  logic [A_W-1:0]          an1_r, an2_r, an3_r;
  logic                    hitn1_r, hitn2_r;
  logic [1:0]              negn2_r;
  logic [MAG_W-1:0]        mag_r [2];
  logic signed [NUM_W-1:0] num_abs [2];
  logic [1:0][A_W-1:0]     rem3_r;
  logic [1:0][Q_W-1:0]     low3_r;
  rsi_div_side_t           dside3_r;
  logic [HI_W-1:0]         hi [2];
  logic [1:0]              ovf3;

  // divider row
  logic                dv_vld  [0:Q_W];
  logic [A_W-1:0]      dv_dvs  [0:Q_W];
  logic [1:0][A_W-1:0] dv_rem  [0:Q_W];
  logic [1:0][Q_W-1:0] dv_low  [0:Q_W];
  logic [1:0][Q_W-1:0] dv_quo  [0:Q_W];
  rsi_div_side_t       dv_side [0:Q_W];

  // output register
  logic                out_valid_r;
  logic                out_hit_r;
  logic [T_W-1:0]      t_r [2];
  logic [T_W-1:0]      t_nxt [2];
  logic [Q_W:0]        mneg [2];
  logic [1:0]          rnz;

  // pipeline moves unless a finished beat is blocked at the output
  assign adv      = !(out_valid_r && out_stall && dv_vld[Q_W]);
  assign in_stall = !adv;

  // valid bits of the stages kept here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r  <= 1'b0;
      vld1_r  <= 1'b0;
      vld2_r  <= 1'b0;
      vld3_r  <= 1'b0;
      vld4_r  <= 1'b0;
      vld8_r  <= 1'b0;
      vldn1_r <= 1'b0;
      vldn2_r <= 1'b0;
      vldn3_r <= 1'b0;
      for (int i = 0; i < MUL_LAT; i++) begin
        dly_vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld0_r       <= in_valid;
      vld1_r       <= vld0_r;
      vld2_r       <= vld1_r;
      vld3_r       <= vld2_r;
      vld4_r       <= vld3_r;
      dly_vld_r[0] <= vld4_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dly_vld_r[i] <= dly_vld_r[i-1];
      end
      vld8_r  <= dly_vld_r[MUL_LAT-1];
      vldn1_r <= sq_vld[ROOT_W];
      vldn2_r <= vldn1_r;
      vldn3_r <= vldn2_r;
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (adv) begin
      org_r[0] <= in_origin_x;
      org_r[1] <= in_origin_y;
      org_r[2] <= in_origin_z;
      dir_r[0] <= in_dir_x;
      dir_r[1] <= in_dir_y;
      dir_r[2] <= in_dir_z;
      ctr_r[0] <= in_center_x;
      ctr_r[1] <= in_center_y;
      ctr_r[2] <= in_center_z;
      rad_r    <= in_radius;
    end
  end

  // oc = origin - center, then the per-axis products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        oc_r[k]   <= OC_W'(org_r[k]) - OC_W'(ctr_r[k]);
        dir1_r[k] <= dir_r[k];
        dd_r[k]   <= dir1_r[k] * dir1_r[k];
        od_r[k]   <= oc_r[k] * dir1_r[k];
        oo_r[k]   <= oc_r[k] * oc_r[k];
      end
      rad1_r <= rad_r;
      rr_r   <= rad1_r * rad1_r;
    end
  end

  // a, half_b and c
  always_comb begin
    hb_nxt = HB_W'(od_r[0]) + HB_W'(od_r[1]) + HB_W'(od_r[2]);
    c_nxt  = C_W'(oo_r[0]) + C_W'(oo_r[1]) + C_W'(oo_r[2]) - signed'(C_W'(rr_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= A_W'(dd_r[0]) + A_W'(dd_r[1]) + A_W'(dd_r[2]);
      hb_r <= hb_nxt;
      c_r  <= c_nxt;
    end
  end

  // magnitudes for the wide multipliers
  assign hb_abs = hb_r[HB_W-1] ? -hb_r : hb_r;
  assign c_abs  = c_r[C_W-1] ? -c_r : c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a4_r    <= a_r;
      hb4_r   <= hb_r;
      cneg4_r <= c_r[C_W-1];
      hbm_r   <= HBM_W'(hb_abs);
      cm_r    <= CM_W'(c_abs);
    end
  end

  // half_b^2 and a*|c|
  rsi_mul #(.AW(HBM_W), .BW(HBM_W)) u_mul_hb2 (
    .clk (clk),
    .en  (adv),
    .a_i (hbm_r),
    .b_i (hbm_r),
    .p_o (hb2)
  );

  rsi_mul #(.AW(A_W), .BW(CM_W)) u_mul_ac (
    .clk (clk),
    .en  (adv),
    .a_i (a4_r),
    .b_i (cm_r),
    .p_o (ac)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_a_r[0]    <= a4_r;
      dly_hb_r[0]   <= hb4_r;
      dly_cneg_r[0] <= cneg4_r;
      for (int i = 1; i < MUL_LAT; i++) begin
        dly_a_r[i]    <= dly_a_r[i-1];
        dly_hb_r[i]   <= dly_hb_r[i-1];
        dly_cneg_r[i] <= dly_cneg_r[i-1];
      end
    end
  end

  // discriminant and hit decision
  assign disc_w = dly_cneg_r[MUL_LAT-1] ? ((DISC_W+1)'(hb2) + (DISC_W+1)'(ac))
                                        : ((DISC_W+1)'(hb2) - (DISC_W+1)'(ac));
  assign hit8   = (dly_a_r[MUL_LAT-1] != '0) && !disc_w[DISC_W];

  always_ff @(posedge clk) begin
    if (adv) begin
      disc8_r   <= hit8 ? disc_w[DISC_W-1:0] : '0;
      sq8_r.a   <= dly_a_r[MUL_LAT-1];
      sq8_r.hb  <= dly_hb_r[MUL_LAT-1];
      sq8_r.hit <= hit8;
    end
  end

  // square-root row, one root bit per cell
  assign sq_vld[0]  = vld8_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = disc8_r;
  assign sq_side[0] = sq8_r;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    rsi_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (sq_vld[g]),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .rad_i  (sq_rad[g]),
      .side_i (sq_side[g]),
      .vld_o  (sq_vld[g+1]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .rad_o  (sq_rad[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  // numerators -half_b - root and -half_b + root
  always_comb begin
    num_nxt[0] = -NUM_W'(sq_side[ROOT_W].hb) - signed'(NUM_W'(sq_root[ROOT_W]));
    num_nxt[1] = -NUM_W'(sq_side[ROOT_W].hb) + signed'(NUM_W'(sq_root[ROOT_W]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= num_nxt;
      an1_r   <= sq_side[ROOT_W].a;
      hitn1_r <= sq_side[ROOT_W].hit;
    end
  end

  // sign and scaled magnitude
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      num_abs[k] = num_r[k][NUM_W-1] ? -num_r[k] : num_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        negn2_r[k] <= num_r[k][NUM_W-1];
        mag_r[k]   <= {num_abs[k][NUM_W-2:0], {FRAC_BITS{1'b0}}};
      end
      an2_r   <= an1_r;
      hitn2_r <= hitn1_r;
    end
  end

  // quotient overflow check and divider preload
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hi[k]   = mag_r[k][MAG_W-1 -: HI_W];
      ovf3[k] = (A_W'(hi[k]) >= an2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        rem3_r[k] <= A_W'(hi[k]);
        low3_r[k] <= mag_r[k][Q_W-1:0];
      end
      an3_r        <= an2_r;
      dside3_r.hit <= hitn2_r;
      dside3_r.neg <= negn2_r;
      dside3_r.ovf <= ovf3;
    end
  end

  // divider row, one quotient bit per cell
  assign dv_vld[0]  = vldn3_r;
  assign dv_dvs[0]  = an3_r;
  assign dv_rem[0]  = rem3_r;
  assign dv_low[0]  = low3_r;
  assign dv_quo[0]  = '0;
  assign dv_side[0] = dside3_r;

  for (genvar g = 0; g < Q_W; g++) begin : g_div
    rsi_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .vld_i  (dv_vld[g]),
      .dvs_i  (dv_dvs[g]),
      .rem_i  (dv_rem[g]),
      .low_i  (dv_low[g]),
      .quo_i  (dv_quo[g]),
      .side_i (dv_side[g]),
      .vld_o  (dv_vld[g+1]),
      .dvs_o  (dv_dvs[g+1]),
      .rem_o  (dv_rem[g+1]),
      .low_o  (dv_low[g+1]),
      .quo_o  (dv_quo[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // floor rounding and saturation
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      rnz[k]  = |dv_rem[Q_W][k];
      mneg[k] = (Q_W+1)'(dv_quo[Q_W][k]) + (Q_W+1)'(rnz[k]);
      if (!dv_side[Q_W].hit) begin
        t_nxt[k] = T_MAX;
      end else if (dv_side[Q_W].neg[k]) begin
        t_nxt[k] = (dv_side[Q_W].ovf[k] || (mneg[k] > NEG_LIM)) ? T_MIN
                                                                : T_W'(-mneg[k]);
      end else begin
        t_nxt[k] = (dv_side[Q_W].ovf[k] || (dv_quo[Q_W][k][Q_W-1:T_W-1] != '0))
                   ? T_MAX : dv_quo[Q_W][k][T_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= dv_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_hit_r <= dv_side[Q_W].hit;
      t_r       <= t_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = out_hit_r;
  assign out_t_near = t_r[0];
  assign out_t_far  = t_r[1];

endmodule

`default_nettype wire
